// ===== rtl/core/afr_pkg.sv =====
// Shared types, sizes and result codes for the addressed frame receiver.
// Used by the channel interfaces, the frame tracker and the top level.
package afr_pkg;

   localparam int PAYLOAD_DEPTH = 4;
   localparam int COUNT_CUTOFF  = 6;
   localparam int OUT_SLOTS     = 4;
   localparam int SHOWN_DEPTH   = (PAYLOAD_DEPTH < OUT_SLOTS) ? PAYLOAD_DEPTH : OUT_SLOTS;
   localparam int COUNT_W       = $clog2(COUNT_CUTOFF + 2);
   localparam int BYTE_W        = 8;
   localparam int ADDR_W        = 16;
   localparam int FLEN_W        = 3;

   localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 16'h2782;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_FRAME = 2'd1,
      EV_ABORT = 2'd2
   } event_type;

   typedef struct packed {
      event_type                   event_res;
      logic [OUT_SLOTS-1:0][BYTE_W-1:0] payload;
      logic [FLEN_W-1:0]           frame_length;
   } result_type;

endpackage

// ===== rtl/core/afr_if.sv =====
// Valid/ready channel interfaces for the received byte, result and address write.
// Depends on afr_pkg for field widths.
interface afr_req_if;
   logic                 valid;
   logic                 ready;
   afr_pkg::byte_type    rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     event_res;
   afr_pkg::byte_type              payload_0;
   afr_pkg::byte_type              payload_1;
   afr_pkg::byte_type              payload_2;
   afr_pkg::byte_type              payload_3;
   logic [afr_pkg::FLEN_W-1:0]     frame_length;
   modport source (output valid, output event_res, output payload_0, output payload_1,
                   output payload_2, output payload_3, output frame_length, input ready);
   modport sink   (input valid, input event_res, input payload_0, input payload_1,
                   input payload_2, input payload_3, input frame_length, output ready);
endinterface

interface afr_csr_if;
   logic                 valid;
   logic                 ready;
   afr_pkg::addr_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/afr_frame.sv =====
// Frame tracker: rolling address, capture state and payload store.
// Computes the result for the current byte and updates state when advanced.
module afr_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  afr_pkg::byte_type   rx_byte,
   input  afr_pkg::addr_type   own_address,
   output afr_pkg::result_type result
);

   afr_pkg::byte_type  older_byte_ff, older_byte_in;
   afr_pkg::byte_type  newer_byte_ff, newer_byte_in;
   logic               capturing_ff, capturing_in;
   afr_pkg::byte_type  expected_length_ff, expected_length_in;
   afr_pkg::count_type captured_count_ff, captured_count_in;
   afr_pkg::byte_type  store_ff [afr_pkg::PAYLOAD_DEPTH];
   afr_pkg::byte_type  store_in [afr_pkg::PAYLOAD_DEPTH];

   afr_pkg::count_type count_inc;
   afr_pkg::byte_type  count_wide;
   afr_pkg::event_type event_code;

   always_comb begin
      count_inc          = captured_count_ff + 1'b1;
      count_wide         = afr_pkg::BYTE_W'(count_inc);
      event_code         = afr_pkg::EV_NONE;
      capturing_in       = capturing_ff;
      expected_length_in = expected_length_ff;
      captured_count_in  = captured_count_ff;
      store_in           = store_ff;

      if (capturing_ff) begin
         for (int i = 0; i < afr_pkg::PAYLOAD_DEPTH; i++) begin
            if (int'(captured_count_ff) == i) begin
               store_in[i] = rx_byte;
            end
         end
         captured_count_in = count_inc;
         if (count_wide == expected_length_ff) begin
            event_code         = afr_pkg::EV_FRAME;
            capturing_in       = 1'b0;
            captured_count_in  = '0;
            expected_length_in = '0;
         end else if (count_inc > afr_pkg::COUNT_W'(afr_pkg::COUNT_CUTOFF)) begin
            event_code         = afr_pkg::EV_ABORT;
            capturing_in       = 1'b0;
            captured_count_in  = '0;
            expected_length_in = '0;
            for (int i = 0; i < afr_pkg::PAYLOAD_DEPTH; i++) begin
               store_in[i] = '0;
            end
         end
      end

      if ({older_byte_ff, newer_byte_ff} == own_address) begin
         capturing_in       = 1'b1;
         expected_length_in = rx_byte;
         captured_count_in  = '0;
      end

      older_byte_in = newer_byte_ff;
      newer_byte_in = rx_byte;
   end

   always_comb begin
      result           = '0;
      result.event_res = event_code;
      if (event_code == afr_pkg::EV_FRAME) begin
         for (int j = 0; j < afr_pkg::SHOWN_DEPTH; j++) begin
            result.payload[j] = store_in[j];
         end
         result.frame_length = afr_pkg::FLEN_W'(count_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_byte_ff      <= '0;
         newer_byte_ff      <= '0;
         capturing_ff       <= 1'b0;
         expected_length_ff <= '0;
         captured_count_ff  <= '0;
         for (int i = 0; i < afr_pkg::PAYLOAD_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (advance) begin
         older_byte_ff      <= older_byte_in;
         newer_byte_ff      <= newer_byte_in;
         capturing_ff       <= capturing_in;
         expected_length_ff <= expected_length_in;
         captured_count_ff  <= captured_count_in;
         store_ff           <= store_in;
      end
   end

endmodule

// ===== rtl/core/addressed_frame_receiver.sv =====
// Top level of the addressed frame receiver: input register, frame tracker,
// result register and the own-address register. Depends on afr_pkg and afr_if.
//
// Each received word yields exactly one result word; it is held in the input
// register and moves into the result register. One word is taken per cycle;
// the input and result registers keep the stream moving while the result
// side stalls, and a new word is refused only when both registers are full.
// The own address resets to 0x2782 and is written through the csr channel,
// which is always ready; write it only while no word is in flight.
module addressed_frame_receiver (
   input logic       clock,
   input logic       reset,
   afr_req_if.sink   req,
   afr_rsp_if.source rsp,
   afr_csr_if.sink   csr
);

   logic                in_valid_ff, in_valid_in;
   afr_pkg::byte_type   in_byte_ff, in_byte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   afr_pkg::result_type rsp_data_ff, rsp_data_in;
   afr_pkg::addr_type   own_address_ff, own_address_in;
   afr_pkg::result_type result;
   logic                advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   afr_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rx_byte     (in_byte_ff),
      .own_address (own_address_ff),
      .result      (result)
   );

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_byte_in     = in_byte_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      own_address_in = own_address_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.rx_byte;
      end
      if (csr.valid && csr.ready) begin
         own_address_in = csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         own_address_ff <= afr_pkg::OWN_ADDRESS_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         own_address_ff <= own_address_in;
      end
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_res    = rsp_data_ff.event_res;
   assign rsp.payload_0    = rsp_data_ff.payload[0];
   assign rsp.payload_1    = rsp_data_ff.payload[1];
   assign rsp.payload_2    = rsp_data_ff.payload[2];
   assign rsp.payload_3    = rsp_data_ff.payload[3];
   assign rsp.frame_length = rsp_data_ff.frame_length;

   // An aborted frame carries a cleared payload and no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.event_res == afr_pkg::EV_ABORT) |->
         (rsp.payload_0 == '0) && (rsp.payload_1 == '0) && (rsp.payload_2 == '0) &&
         (rsp.payload_3 == '0) && (rsp.frame_length == '0))
      else $error("abort result carries payload or length");

   // Only a completed frame reports a nonzero length.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.event_res != afr_pkg::EV_FRAME) |-> rsp.frame_length == '0)
      else $error("length reported without a completed frame");

   // A held input word is not lost while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp.ready |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input word dropped during result stall");

   // A new word is refused only when both registers hold data.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && rsp_valid_ff)
      else $error("input refused with free register space");

endmodule
